FILE: hdl/elc_pkg.sv
package elc_pkg;

  // fixed scaling of the encoder and the table
  localparam int CPR_BITS       = 14;
  localparam int COUNTS_PER_REV = 1 << CPR_BITS;
  localparam int TABLE_BITS     = 6;
  localparam int TABLE_SIZE     = 1 << TABLE_BITS;
  localparam int SPP_BITS       = 4;
  localparam int SAMPLES_PER_PAIR = 1 << SPP_BITS;
  localparam int MAX_POLE_PAIRS = 32;
  localparam int STORE_DEPTH    = MAX_POLE_PAIRS * SAMPLES_PER_PAIR;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int N_W            = ADDR_W + 1;

  // shared divider: angle * counts over pole_pairs * 2^16, and the store sum over n
  localparam int DIV_DW = 32 + CPR_BITS;
  localparam int DIV_VW = 22;

  typedef enum logic [1:0] {
    REG_POLE_PAIRS = 2'd0,
    REG_SETTLE     = 2'd1,
    REG_INTERVAL   = 2'd2,
    REG_STEP       = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_FWD    = 2'd2,
    PH_REV    = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLASS,
    ST_DIV,
    ST_OUT,
    ST_SUM,
    ST_MDIV,
    ST_EBASE,
    ST_EACC,
    ST_TOUT
  } state_t;

  typedef struct packed {
    logic        done;
    logic        last;
    logic [14:0] mean;
    logic [15:0] value;
    logic [5:0]  index;
    logic        lvalid;
    logic        on;
    logic [15:0] angle;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/elc_div.sv
module elc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [elc_pkg::DIV_DW-1:0] dividend,
  input  logic [elc_pkg::DIV_VW-1:0] divisor,
  output elc_pkg::div_stat_t         stat,
  output logic [elc_pkg::DIV_DW-1:0] quotient
);
  import elc_pkg::*;

  localparam int CNT_W = $clog2(DIV_DW);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_DW-1:0] dq_r;
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_VW:0]   rem_sh;
  logic              fits;

  // one quotient bit a cycle, restoring
  assign rem_sh = {rem_r, dq_r[DIV_DW-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(DIV_DW - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(DIV_DW - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      dq_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      dq_r  <= {dq_r[DIV_DW-2:0], fits};
      rem_r <= fits ? DIV_VW'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_VW-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

FILE: hdl/encoder_linearization_calibrator.sv
// channel  | direction | beat contents
// in_      | slave     | tdata: encoder_raw, one control tick per beat
// out_     | master    | tdata: drive angle, flags, table entry; tlast, tuser: done_res
// cfg_     | slave     | cfg_index selects the register, cfg_data the value
//
// one tick per input beat; ready only while idle
// settle ticks: the accept, then the output beat
// non-sampling ramp ticks: accept, multiply, classify and the output beat
// sampling ramp ticks: accept, multiply, classify, the bit-serial 46-step divider, output beat
// final tick: multiply, classify, sum the store, divide for the mean, then per table
//   entry a base step, 16 store reads through the single read port and the output beat
// synchronous active-low reset; the error store itself is not cleared
// an output stall holds the block in its output state, no input is taken
module encoder_linearization_calibrator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [13:0] encoder_raw
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [15:0] drive_angle, [16] drive_on, [17] lut_valid,
                                   // [23:18] table_pos, [39:24] lut_value,
                                   // [54:40] offset_mean
  output logic        out_tlast,
  output logic        out_tuser,   // [0] done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import elc_pkg::*;

  // configuration
  logic [5:0]  pp_r;
  logic [19:0] settle_r;
  logic [15:0] intv_r;
  logic [15:0] step_r;

  // run state
  state_t      st_r, st_nxt;
  phase_t      ph_r, ph_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] ang_r, ang_nxt;
  logic [31:0] next_r, next_nxt;
  logic [N_W-1:0] sidx_r, sidx_nxt;

  // per-tick working registers
  logic [CPR_BITS-1:0] raw_r, raw_nxt;
  logic [31:0] t_r, t_nxt;
  logic [47:0] prod_r, prod_nxt;
  res_t        res_r, res_nxt;

  // final-tick working registers
  logic [N_W-1:0]    cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [22:0]       sum_r, sum_nxt;
  logic [CPR_BITS-1:0] s0_r, s0_nxt;
  logic [14:0]       mean_r, mean_nxt;
  logic [TABLE_BITS-1:0] i_r, i_nxt;
  logic [N_W-1:0]    base_r, base_nxt;
  logic [SPP_BITS:0] j_r, j_nxt;
  logic [CPR_BITS+SPP_BITS-1:0] acc_r, acc_nxt;

  // error store
  logic [CPR_BITS-1:0] mem [STORE_DEPTH];
  logic [CPR_BITS-1:0] rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [CPR_BITS-1:0] wr_data;
  logic                wr_en;

  // shared divider
  logic              div_start;
  logic [DIV_DW-1:0] div_a;
  logic [DIV_VW-1:0] div_b;
  div_stat_t         div_stat;
  logic [DIV_DW-1:0] div_q;

  // helpers
  logic [N_W-1:0]    n_w;
  logic              pp_bad;
  logic [31:0]       t_start;
  logic [47:0]       span;
  logic [31:0]       ang_up, ang_dn;
  logic [CPR_BITS-1:0] err;
  logic [N_W:0]      w, idx0, idx;
  logic [22:0]       sum_fin;
  logic [CPR_BITS+SPP_BITS-1:0] acc_fin;
  logic [CPR_BITS:0] offs;
  logic [15:0]       bprod;

  assign n_w     = {pp_r, {SPP_BITS{1'b0}}};
  assign pp_bad  = (pp_r == '0) || (pp_r > 6'(MAX_POLE_PAIRS));
  assign t_start = (ph_r == PH_IDLE) ? 32'd0 : tick_r;
  assign span    = {26'd0, pp_r, 16'd0};
  assign ang_up  = ang_r + {16'd0, step_r};
  assign ang_dn  = ang_r - {16'd0, step_r};
  assign err     = raw_r - div_q[CPR_BITS-1:0];
  assign sum_fin = sum_r + (pend_r ? {9'd0, rd_data_r} : 23'd0);
  assign acc_fin = acc_r + (pend_r ? {{SPP_BITS{1'b0}}, rd_data_r} : '0);
  assign offs    = (CPR_BITS+1)'(COUNTS_PER_REV) - {1'b0, s0_r};
  assign bprod   = {10'd0, i_r} * {6'd0, n_w};

  // circular window index around the entry's base
  assign w    = {1'b0, base_r} + {{(N_W-SPP_BITS){1'b0}}, j_r};
  assign idx0 = (w < (N_W+1)'(SAMPLES_PER_PAIR / 2))
              ? w + {1'b0, n_w} - (N_W+1)'(SAMPLES_PER_PAIR / 2)
              : w - (N_W+1)'(SAMPLES_PER_PAIR / 2);
  assign idx  = (idx0 >= {1'b0, n_w}) ? idx0 - {1'b0, n_w} : idx0;

  elc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // config port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r     <= 6'd21;
      settle_r <= 20'd40000;
      intv_r   <= 16'd100;
      step_r   <= 16'd128;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POLE_PAIRS: pp_r     <= cfg_data[5:0];
        REG_SETTLE:     settle_r <= cfg_data;
        REG_INTERVAL:   intv_r   <= cfg_data[15:0];
        REG_STEP:       step_r   <= cfg_data[15:0];
      endcase
    end
  end

  // error store, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ph_r   <= PH_IDLE;
      tick_r <= '0;
      ang_r  <= '0;
      next_r <= '0;
      sidx_r <= '0;
      pend_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      tick_r <= tick_nxt;
      ang_r  <= ang_nxt;
      next_r <= next_nxt;
      sidx_r <= sidx_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r  <= raw_nxt;
    t_r    <= t_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    cnt_r  <= cnt_nxt;
    sum_r  <= sum_nxt;
    s0_r   <= s0_nxt;
    mean_r <= mean_nxt;
    i_r    <= i_nxt;
    base_r <= base_nxt;
    j_r    <= j_nxt;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    ph_nxt    = ph_r;
    tick_nxt  = tick_r;
    ang_nxt   = ang_r;
    next_nxt  = next_r;
    sidx_nxt  = sidx_r;
    raw_nxt   = raw_r;
    t_nxt     = t_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    sum_nxt   = sum_r;
    s0_nxt    = s0_r;
    mean_nxt  = mean_r;
    i_nxt     = i_r;
    base_nxt  = base_r;
    j_nxt     = j_r;
    acc_nxt   = acc_r;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    div_start = 1'b0;
    div_a     = {ang_up, {CPR_BITS{1'b0}}};
    div_b     = {pp_r, 16'd0};
    rd_addr   = sidx_r[ADDR_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = sidx_r[ADDR_W-1:0];
    wr_data   = err;

    unique case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          raw_nxt = in_tdata[CPR_BITS-1:0];
          res_nxt = '0;
          res_nxt.last = 1'b1;
          if (pp_bad) begin
            st_nxt = ST_OUT;
          end else begin
            if (ph_r == PH_IDLE) begin
              sidx_nxt = '0;
              next_nxt = {12'd0, settle_r};
            end
            t_nxt    = t_start;
            tick_nxt = t_start + 32'd1;
            if (t_start < {12'd0, settle_r}) begin
              ph_nxt     = PH_SETTLE;
              ang_nxt    = '0;
              next_nxt   = t_start;
              res_nxt.on = 1'b1;
              st_nxt     = ST_OUT;
            end else begin
              st_nxt = ST_MUL;
            end
          end
        end
      end

      ST_MUL: begin
        prod_nxt = {16'd0, t_r - {12'd0, settle_r}} * {32'd0, step_r};
        st_nxt   = ST_CLASS;
      end

      ST_CLASS: begin
        if (prod_r < span) begin
          ph_nxt  = PH_FWD;
          ang_nxt = ang_up;
          res_nxt.angle = ang_up[15:0];
          res_nxt.on    = 1'b1;
          if (t_r > next_r) begin
            div_start = 1'b1;
            st_nxt    = ST_DIV;
          end else begin
            st_nxt = ST_OUT;
          end
        end else if (prod_r < {span[46:0], 1'b0}) begin
          ph_nxt  = PH_REV;
          ang_nxt = ang_dn;
          res_nxt.angle = ang_dn[15:0];
          res_nxt.on    = 1'b1;
          div_a   = {ang_dn, {CPR_BITS{1'b0}}};
          if ((t_r > next_r) && (sidx_r != '0)) begin
            div_start = 1'b1;
            st_nxt    = ST_DIV;
          end else begin
            st_nxt = ST_OUT;
          end
        end else begin
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          sum_nxt  = '0;
          st_nxt   = ST_SUM;
        end
      end

      ST_DIV: begin
        if (div_stat.done) begin
          next_nxt = next_r + {16'd0, intv_r};
          if (ph_r == PH_FWD) begin
            wr_en = sidx_r < n_w;
            if (sidx_r < n_w - 1'b1) begin
              sidx_nxt = sidx_r + 1'b1;
            end
          end else begin
            wr_en    = sidx_r < n_w;
            wr_data  = CPR_BITS'(({1'b0, rd_data_r} + {1'b0, err}) >> 1);
            sidx_nxt = sidx_r - 1'b1;
          end
          st_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          st_nxt = ST_IDLE;
        end
      end

      // walk the store once: sum and first entry
      ST_SUM: begin
        rd_addr  = cnt_r[ADDR_W-1:0];
        pend_nxt = cnt_r < n_w;
        sum_nxt  = sum_fin;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == N_W'(1)) begin
          s0_nxt = rd_data_r;
        end
        if (cnt_r == n_w) begin
          div_start = 1'b1;
          div_a     = {23'd0, sum_fin};
          div_b     = {12'd0, n_w};
          st_nxt    = ST_MDIV;
        end
      end

      // the divisor is read on every step, so it stays on the sample count
      ST_MDIV: begin
        div_b = {12'd0, n_w};
        if (div_stat.done) begin
          mean_nxt = div_q[14:0];
          i_nxt    = '0;
          st_nxt   = ST_EBASE;
        end
      end

      ST_EBASE: begin
        base_nxt = bprod[TABLE_BITS +: N_W];
        j_nxt    = '0;
        acc_nxt  = '0;
        pend_nxt = 1'b0;
        st_nxt   = ST_EACC;
      end

      // moving-average window, one store read a cycle
      ST_EACC: begin
        rd_addr  = idx[ADDR_W-1:0];
        pend_nxt = j_r < (SPP_BITS+1)'(SAMPLES_PER_PAIR);
        acc_nxt  = acc_fin;
        j_nxt    = j_r + 1'b1;
        if (j_r == (SPP_BITS+1)'(SAMPLES_PER_PAIR)) begin
          res_nxt        = '0;
          res_nxt.lvalid = 1'b1;
          res_nxt.done   = 1'b1;
          res_nxt.mean   = mean_r;
          res_nxt.index  = offs[CPR_BITS-TABLE_BITS +: TABLE_BITS] + i_r;
          res_nxt.value  = {2'b00, acc_fin[SPP_BITS +: CPR_BITS]} - {1'b0, mean_r};
          res_nxt.last   = i_r == TABLE_BITS'(TABLE_SIZE - 1);
          st_nxt         = ST_TOUT;
        end
      end

      ST_TOUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (i_r == TABLE_BITS'(TABLE_SIZE - 1)) begin
            ph_nxt  = PH_IDLE;
            ang_nxt = '0;
            st_nxt  = ST_IDLE;
          end else begin
            i_nxt  = i_r + 1'b1;
            st_nxt = ST_EBASE;
          end
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_tdata = {1'b0, res_r.mean, res_r.value, res_r.index,
                      res_r.lvalid, res_r.on, res_r.angle};
  assign out_tlast = res_r.last;
  assign out_tuser = res_r.done;

endmodule

FILE: hdl/elc_chk.sv
module elc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // one tick at a time: no input taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready straight after an accepted tick");

  // table beats carry an entry and no drive
  a_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[17] && !out_tdata[16] && out_tdata[15:0] == 16'd0)
    else $error("table beat with drive or without entry");

endmodule

bind encoder_linearization_calibrator elc_chk u_elc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

FILE: test/tb_encoder_linearization_calibrator.sv
module tb_encoder_linearization_calibrator;
  import elc_pkg::*;

  // calibration predictor and store of expected beats
  class calib_scoreboard;
    logic [5:0]  pole_pairs;
    logic [19:0] settle_ticks;
    logic [15:0] interval;
    logic [15:0] step;
    phase_t      phase;
    bit [31:0]   ticks;
    bit [31:0]   angle;
    bit [31:0]   next_sample;
    int unsigned sidx;
    bit [14:0]   err_store [STORE_DEPTH];
    res_t        pending [$];
    int          errors;

    function new();
      pole_pairs   = 21;
      settle_ticks = 40000;
      interval     = 100;
      step         = 128;
      phase        = PH_IDLE;
      ticks        = 0;
      angle        = 0;
      next_sample  = 0;
      sidx         = 0;
      errors       = 0;
      foreach (err_store[i]) err_store[i] = '0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [19:0] v);
      case (r)
        REG_POLE_PAIRS: pole_pairs   = v[5:0];
        REG_SETTLE:     settle_ticks = v;
        REG_INTERVAL:   interval     = v[15:0];
        REG_STEP:       step         = v[15:0];
        default: ;
      endcase
    endfunction

    // position error against the drive angle, wrapped non-negative
    function bit [14:0] pos_error(logic [13:0] raw, int unsigned pp);
      longint unsigned cref;
      cref = ({32'd0, angle} * COUNTS_PER_REV) / (64'd65536 * pp);
      cref = cref % COUNTS_PER_REV;
      return 15'((raw + COUNTS_PER_REV - cref) % COUNTS_PER_REV);
    endfunction

    function void push_ramp(logic [15:0] ang);
      res_t r;
      r       = '0;
      r.angle = ang;
      r.on    = 1'b1;
      r.last  = 1'b1;
      pending.push_back(r);
    endfunction

    function void note_tick(logic [13:0] raw);
      int unsigned     pp, n, t, mean, offset, base, idx, avg;
      longint unsigned k, span, sum, acc;
      bit [14:0]       e;
      res_t            r;
      pp = pole_pairs;
      if (pp == 0 || pp > MAX_POLE_PAIRS) begin
        // bad pole count: tick ignored, one empty beat
        r      = '0;
        r.last = 1'b1;
        pending.push_back(r);
        return;
      end
      n = pp * SAMPLES_PER_PAIR;
      if (phase == PH_IDLE) begin
        ticks       = 0;
        sidx        = 0;
        next_sample = settle_ticks;
      end
      t     = ticks;
      ticks = t + 1;
      if (t < settle_ticks) begin
        phase       = PH_SETTLE;
        angle       = 0;
        next_sample = t;
        push_ramp(16'd0);
        return;
      end
      k    = longint'(32'(t - settle_ticks)) * step;
      span = longint'(pp) * 65536;
      if (k < span) begin
        phase = PH_FWD;
        angle = angle + step;
        if (t > next_sample) begin
          e = pos_error(raw, pp);
          if (sidx < n) err_store[sidx] = e;
          next_sample = next_sample + interval;
          if (sidx < n - 1) sidx++;
        end
        push_ramp(angle[15:0]);
        return;
      end
      if (k < 2 * span) begin
        phase = PH_REV;
        angle = angle - step;
        if (t > next_sample && sidx > 0) begin
          e = pos_error(raw, pp);
          if (sidx < n) err_store[sidx] = 15'((err_store[sidx] + e) / 2);
          sidx--;
          next_sample = next_sample + interval;
        end
        push_ramp(angle[15:0]);
        return;
      end
      // final tick: mean offset, then the smoothed table rotated by the first sample
      sum = 0;
      for (int i = 0; i < n; i++) sum += err_store[i];
      mean   = sum / n;
      offset = ((COUNTS_PER_REV - err_store[0] % COUNTS_PER_REV) * TABLE_SIZE)
               / COUNTS_PER_REV;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        base = (i * n) / TABLE_SIZE;
        acc  = 0;
        for (int j = -SAMPLES_PER_PAIR / 2; j < SAMPLES_PER_PAIR / 2; j++) begin
          idx = (int'(base) + j + int'(n)) % int'(n);
          acc += err_store[idx];
        end
        avg      = acc / SAMPLES_PER_PAIR;
        r        = '0;
        r.lvalid = 1'b1;
        r.index  = 6'((offset + i) % TABLE_SIZE);
        r.value  = 16'(int'(avg) - int'(mean));
        r.mean   = 15'(mean);
        r.last   = (i == TABLE_SIZE - 1);
        r.done   = 1'b1;
        pending.push_back(r);
      end
      angle = 0;
      phase = PH_IDLE;
    endfunction

    function void cmp(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check(res_t got);
      res_t x;
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      x = pending.pop_front();
      cmp("drive_angle", x.angle,  got.angle);
      cmp("drive_on",    x.on,     got.on);
      cmp("lut_valid",   x.lvalid, got.lvalid);
      cmp("table_pos",   x.index,  got.index);
      cmp("lut_value",   x.value,  got.value);
      cmp("offset_mean", x.mean,   got.mean);
      cmp("last",        x.last,   got.last);
      cmp("done_res",    x.done,   got.done);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  calib_scoreboard sb;
  int  tx_idle;      // sender idle chance per hundred
  int  rx_idle;      // receiver idle chance per hundred
  bit  hold_req;     // ask the receiver for a long hold-off
  int  ticks_sent;   // ticks accepted so far

  encoder_linearization_calibrator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 8 unit clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    bit hold_used;
    out_tready = 1'b0;
    hold       = 0;
    hold_used  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold      = 400;
        hold_used = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // every accepted result beat is checked against the oldest expectation
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got        = '0;
      got.angle  = out_tdata[15:0];
      got.on     = out_tdata[16];
      got.lvalid = out_tdata[17];
      got.index  = out_tdata[23:18];
      got.value  = out_tdata[39:24];
      got.mean   = out_tdata[54:40];
      got.last   = out_tlast;
      got.done   = out_tuser;
      sb.check(got);
    end
  end

  // one control tick; valid stays high between back-to-back beats
  task automatic send_tick(logic [13:0] raw);
    // idling: sender light and receiver heavy, then swapped, then none
    if (ticks_sent >= 146) begin
      tx_idle = 0;
      rx_idle = 0;
    end else if (ticks_sent >= 73) begin
      tx_idle = 83;
      rx_idle = 14;
    end
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {2'b00, raw};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(raw);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic rand_ticks_n(int n);
    for (int i = 0; i < n; i++) send_tick(14'($urandom));
  endtask

  // register writes only once the block has drained
  task automatic write_reg(cfg_reg_t r, logic [19:0] v);
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(r, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one complete calibration run of the current settings
  task automatic full_run(int settle, int pp, int stp);
    int n;
    n = settle + (2 * pp * 65536 + stp - 1) / stp + 1;
    rand_ticks_n(n);
  endtask

  initial begin
    int pp, stp, step_min, settle, ivl;
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_POLE_PAIRS;
    cfg_data   = '0;
    tx_idle    = 14;
    rx_idle    = 83;
    hold_req   = 1'b0;
    ticks_sent = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // bad pole counts: zero and above the maximum are ignored
    write_reg(REG_POLE_PAIRS, 20'd0);
    send_tick(14'd0);
    send_tick(14'h3fff);
    write_reg(REG_POLE_PAIRS, 20'd63);
    write_reg(REG_STEP, 20'd1);
    send_tick(14'h2aaa);
    send_tick(14'h1555);

    // longest settle and sample interval, just a few settle ticks
    write_reg(REG_POLE_PAIRS, 20'd32);
    write_reg(REG_SETTLE, 20'hfffff);
    write_reg(REG_INTERVAL, 20'hffff);
    send_tick(14'd0);
    send_tick(14'h3fff);
    send_tick(14'd7);

    // pull settle back to the ticks already spent and finish a full 4-pair run;
    // this writes the first 64 store entries, so later runs of up to four pairs
    // read old samples only
    write_reg(REG_POLE_PAIRS, 20'd4);
    write_reg(REG_SETTLE, 20'd3);
    write_reg(REG_INTERVAL, 20'd1);
    write_reg(REG_STEP, 20'd4096);
    send_tick(14'h3fff);
    send_tick(14'd0);
    hold_req = 1'b1;   // receiver holds off; the sender waits on in_tready meanwhile
    rand_ticks_n(127);

    // random runs of up to four pole pairs with short ramps
    while (ticks_sent < 220) begin
      if ($urandom_range(9) == 0) begin
        // noise: ticks under a bad pole count
        write_reg(REG_POLE_PAIRS, $urandom_range(1) ? 20'd0 : 20'($urandom_range(63, 33)));
        rand_ticks_n($urandom_range(3, 1));
      end
      pp       = $urandom_range(4, 1);
      step_min = (2 * pp * 65536 + 59) / 60;
      stp      = (step_min > 65535) ? 65535 : $urandom_range(65535, step_min);
      settle   = $urandom_range(5, 1);
      ivl      = ($urandom_range(9) == 0) ? 65535 : $urandom_range(6, 1);
      write_reg(REG_POLE_PAIRS, 20'(pp));
      write_reg(REG_SETTLE, 20'(settle));
      write_reg(REG_INTERVAL, 20'(ivl));
      write_reg(REG_STEP, 20'(stp));
      full_run(settle, pp, stp);
    end

    // drain
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
